[hdl/mtq_pkg.sv]
package mtq_pkg;

  localparam int MulW  = 36;
  localparam int ProdW = 2 * MulW;
  localparam int NumW  = 35;
  localparam int DenW  = 33;
  localparam int CW    = 36;
  localparam int DvdW  = 64;
  localparam int CntW  = 6;
  localparam int BarsW = 5;

  localparam logic OP_BAR    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef logic signed [MulW-1:0]  mul_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [CW-1:0]    coef_t;

  typedef struct packed {
    logic                   start;
    logic signed [NumW-1:0] num;
    logic [DenW-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[hdl/magnetorquer_torque_from_dipoles.sv]
// Torque bar dipole summing and torque calculation. A bar beat clamps the
// command to its limit and adds command times axis into the dipole sum, in
// acceptance plus three multiply and write-back pairs on the shared
// multiplier. A finish beat builds the rotation from the attitude MRP,
// rotates the field, forms dipole cross body field and offers one result;
// its work is dominated by nine runs of the bit-serial divider. in_stall is
// high for the whole of each beat's work and while a result waits on
// out_stall. Bar beats beyond MAX_BARS are taken and dropped.
module magnetorquer_torque_from_dipoles
  import mtq_pkg::*;
#(
  parameter int MAX_BARS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [23:0] in_dipole_cmd,
  input  logic [22:0]        in_dipole_limit,
  input  logic signed [17:0] in_axis_x,
  input  logic signed [17:0] in_axis_y,
  input  logic signed [17:0] in_axis_z,
  input  logic signed [31:0] in_mrp_one,
  input  logic signed [31:0] in_mrp_two,
  input  logic signed [31:0] in_mrp_three,
  input  logic signed [25:0] in_field_n_x,
  input  logic signed [25:0] in_field_n_y,
  input  logic signed [25:0] in_field_n_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_torque_x,
  output logic signed [47:0] out_torque_y,
  output logic signed [47:0] out_torque_z
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_WB    = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [1:0] PH_BAR = 2'd0;
  localparam logic [1:0] PH_PRE = 2'd1;
  localparam logic [1:0] PH_MAT = 2'd2;
  localparam logic [1:0] PH_CRS = 2'd3;

  localparam logic [3:0] K_SQ1 = 4'd0;
  localparam logic [3:0] K_SQ2 = 4'd1;
  localparam logic [3:0] K_SQ3 = 4'd2;
  localparam logic [3:0] K_P12 = 4'd3;
  localparam logic [3:0] K_P13 = 4'd4;
  localparam logic [3:0] K_P23 = 4'd5;
  localparam logic [3:0] K_OM2 = 4'd6;
  localparam logic [3:0] K_DEN = 4'd7;
  localparam logic [3:0] K_A1  = 4'd8;
  localparam logic [3:0] K_A2  = 4'd9;
  localparam logic [3:0] K_A3  = 4'd10;

  localparam logic [BarsW-1:0] MaxBars = BarsW'(MAX_BARS);
  localparam logic signed [31:0] MrpMax = 32'sh4000_0000;
  localparam logic signed [31:0] MrpMin = -32'sh4000_0000;
  localparam logic signed [63:0] Half27 = 64'sh0000_0000_0800_0000;
  localparam logic signed [63:0] Half29 = 64'sh0000_0000_2000_0000;
  localparam logic signed [30:0] OneQ28 = 31'sh1000_0000;
  localparam logic signed [56:0] TqMax = 57'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [56:0] TqMin = -57'sh0000_8000_0000_0000;

  logic [2:0]          state_r;
  logic [1:0]          phase_r;
  logic [3:0]          step_r;
  logic [1:0]          row_r;
  logic [1:0]          col_r;
  logic [3:0]          d_r;
  logic [BarsW-1:0]    bars_r;
  logic                out_valid_r;

  logic signed [23:0]  cmd_r;
  logic signed [17:0]  ax_r [3];
  logic signed [29:0]  s_r [3];
  logic signed [25:0]  bn_r [3];
  logic signed [29:0]  sq_r [3];
  logic signed [29:0]  p12_r;
  logic signed [29:0]  p13_r;
  logic signed [29:0]  p23_r;
  logic signed [31:0]  om2_r;
  logic [DenW-1:0]     den_r;
  logic signed [30:0]  a_r [3];
  coef_t               c_r [9];
  logic signed [63:0]  acc_r;
  logic signed [33:0]  bb_r [3];
  logic signed [47:0]  tq_r [3];
  logic signed [47:0]  dsum_r [3];

  logic                in_acc;
  logic signed [24:0]  cmd_x;
  logic signed [24:0]  lim_x;
  logic signed [23:0]  cmd_cl;
  logic signed [29:0]  mrp_q [3];
  logic signed [31:0]  mrp_raw [3];
  logic signed [30:0]  ss;
  logic signed [30:0]  om;
  logic signed [31:0]  op;
  logic signed [31:0]  m [3];
  mul_t                mul_a;
  mul_t                mul_b;
  prod_t               mul_p;
  logic signed [63:0]  prod64;
  logic signed [63:0]  r28;
  logic signed [63:0]  acc_sum;
  logic signed [63:0]  bb_full;
  logic signed [63:0]  t_diff;
  logic signed [64:0]  t_rnd;
  logic signed [56:0]  t_sh;
  logic signed [47:0]  t_sat;
  logic [3:0]          cidx;
  logic signed [NumW-1:0] sqx [3];
  logic signed [NumW-1:0] om2x;
  logic signed [NumW-1:0] p12x;
  logic signed [NumW-1:0] p13x;
  logic signed [NumW-1:0] p23x;
  logic signed [NumW-1:0] ax [3];
  logic signed [NumW-1:0] num;
  div_req_t            dv_req;
  div_sts_t            dv_sts;
  coef_t               dv_quo;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign cmd_x  = 25'(in_dipole_cmd);
  assign lim_x  = signed'({2'b00, in_dipole_limit});
  assign cmd_cl = (cmd_x > lim_x) ? 24'(lim_x) :
                  (cmd_x < -lim_x) ? 24'(-lim_x) : in_dipole_cmd;

  assign mrp_raw[0] = in_mrp_one;
  assign mrp_raw[1] = in_mrp_two;
  assign mrp_raw[2] = in_mrp_three;

  always_comb begin
    logic signed [31:0] sc;
    logic signed [32:0] sr;
    for (int i = 0; i < 3; i++) begin
      sc = (mrp_raw[i] > MrpMax) ? MrpMax : (mrp_raw[i] < MrpMin) ? MrpMin : mrp_raw[i];
      sr = (33'(sc) + 33'sd2) >>> 2;
      mrp_q[i] = sr[29:0];
    end
  end

  assign ss = 31'(sq_r[0]) + 31'(sq_r[1]) + 31'(sq_r[2]);
  assign om = OneQ28 - ss;
  assign op = 32'(OneQ28) + 32'(ss);

  always_comb begin
    logic signed [48:0] mr;
    for (int i = 0; i < 3; i++) begin
      mr = (49'(dsum_r[i]) + 49'sh8000) >>> 16;
      m[i] = mr[31:0];
    end
  end

  assign cidx = {1'b0, row_r, 1'b0} + {2'b00, row_r} + {2'b00, col_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (phase_r)
      PH_BAR: begin
        mul_a = MulW'(cmd_r);
        mul_b = MulW'(ax_r[step_r[1:0]]);
      end
      PH_PRE: begin
        case (step_r)
          K_SQ1: begin mul_a = MulW'(s_r[0]); mul_b = MulW'(s_r[0]); end
          K_SQ2: begin mul_a = MulW'(s_r[1]); mul_b = MulW'(s_r[1]); end
          K_SQ3: begin mul_a = MulW'(s_r[2]); mul_b = MulW'(s_r[2]); end
          K_P12: begin mul_a = MulW'(s_r[0]); mul_b = MulW'(s_r[1]); end
          K_P13: begin mul_a = MulW'(s_r[0]); mul_b = MulW'(s_r[2]); end
          K_P23: begin mul_a = MulW'(s_r[1]); mul_b = MulW'(s_r[2]); end
          K_OM2: begin mul_a = MulW'(om); mul_b = MulW'(om); end
          K_DEN: begin mul_a = MulW'(op); mul_b = MulW'(op); end
          K_A1:  begin mul_a = MulW'(s_r[0]); mul_b = MulW'(om); end
          K_A2:  begin mul_a = MulW'(s_r[1]); mul_b = MulW'(om); end
          K_A3:  begin mul_a = MulW'(s_r[2]); mul_b = MulW'(om); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      PH_MAT: begin
        mul_a = c_r[cidx];
        mul_b = MulW'(bn_r[col_r]);
      end
      PH_CRS: begin
        case (step_r)
          4'd0: begin mul_a = MulW'(m[1]); mul_b = MulW'(bb_r[2]); end
          4'd1: begin mul_a = MulW'(m[2]); mul_b = MulW'(bb_r[1]); end
          4'd2: begin mul_a = MulW'(m[2]); mul_b = MulW'(bb_r[0]); end
          4'd3: begin mul_a = MulW'(m[0]); mul_b = MulW'(bb_r[2]); end
          4'd4: begin mul_a = MulW'(m[0]); mul_b = MulW'(bb_r[1]); end
          4'd5: begin mul_a = MulW'(m[1]); mul_b = MulW'(bb_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  mtq_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign prod64  = mul_p[63:0];
  assign r28     = (prod64 + Half27) >>> 28;
  assign acc_sum = ((col_r == 2'd0) ? 64'sd0 : acc_r) + prod64;
  assign bb_full = (acc_sum + Half29) >>> 30;
  assign t_diff  = acc_r - prod64;
  assign t_rnd   = 65'(t_diff) + 65'sd128;
  assign t_sh    = 57'(t_rnd >>> 8);
  assign t_sat   = (t_sh > TqMax) ? 48'(TqMax) : (t_sh < TqMin) ? 48'(TqMin) : t_sh[47:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqx[i] = NumW'(sq_r[i]);
      ax[i]  = NumW'(a_r[i]);
    end
  end
  assign om2x = NumW'(om2_r);
  assign p12x = NumW'(p12_r);
  assign p13x = NumW'(p13_r);
  assign p23x = NumW'(p23_r);

  always_comb begin
    case (d_r)
      4'd0: num = ((sqx[0] - sqx[1] - sqx[2]) <<< 2) + om2x;
      4'd1: num = (p12x <<< 3) + (ax[2] <<< 2);
      4'd2: num = (p13x <<< 3) - (ax[1] <<< 2);
      4'd3: num = (p12x <<< 3) - (ax[2] <<< 2);
      4'd4: num = ((sqx[1] - sqx[0] - sqx[2]) <<< 2) + om2x;
      4'd5: num = (p23x <<< 3) + (ax[0] <<< 2);
      4'd6: num = (p13x <<< 3) + (ax[1] <<< 2);
      4'd7: num = (p23x <<< 3) - (ax[0] <<< 2);
      4'd8: num = ((sqx[2] - sqx[0] - sqx[1]) <<< 2) + om2x;
      default: num = '0;
    endcase
  end

  assign dv_req = '{start: (state_r == ST_DIV), num: num, den: den_r};

  mtq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dv_req),
    .sts   (dv_sts),
    .quo   (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_BAR;
      step_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      d_r         <= '0;
      bars_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) dsum_r[i] <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            step_r <= '0;
            if (in_operation == OP_FINISH) begin
              phase_r <= PH_PRE;
              state_r <= ST_MUL;
            end else if (bars_r < MaxBars) begin
              phase_r <= PH_BAR;
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: state_r <= ST_WB;
        ST_WB: begin
          unique case (phase_r)
            PH_BAR: begin
              dsum_r[step_r[1:0]] <= dsum_r[step_r[1:0]] + prod64[47:0];
              if (step_r == 4'd2) begin
                bars_r  <= bars_r + 1'b1;
                state_r <= ST_IDLE;
              end else begin
                step_r  <= step_r + 1'b1;
                state_r <= ST_MUL;
              end
            end
            PH_PRE: begin
              if (step_r == K_A3) begin
                d_r     <= '0;
                state_r <= ST_DIV;
              end else begin
                step_r  <= step_r + 1'b1;
                state_r <= ST_MUL;
              end
            end
            PH_MAT: begin
              state_r <= ST_MUL;
              if (col_r == 2'd2) begin
                col_r <= '0;
                if (row_r == 2'd2) begin
                  phase_r <= PH_CRS;
                  step_r  <= '0;
                end else begin
                  row_r <= row_r + 1'b1;
                end
              end else begin
                col_r <= col_r + 1'b1;
              end
            end
            PH_CRS: begin
              if (step_r == 4'd5) begin
                state_r     <= ST_OUT;
                out_valid_r <= 1'b1;
                bars_r      <= '0;
                for (int i = 0; i < 3; i++) dsum_r[i] <= '0;
              end else begin
                step_r  <= step_r + 1'b1;
                state_r <= ST_MUL;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_DIV: state_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (dv_sts.done) begin
            if (d_r == 4'd8) begin
              phase_r <= PH_MAT;
              row_r   <= '0;
              col_r   <= '0;
              state_r <= ST_MUL;
            end else begin
              d_r     <= d_r + 1'b1;
              state_r <= ST_DIV;
            end
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= cmd_cl;
      ax_r[0]  <= in_axis_x;
      ax_r[1]  <= in_axis_y;
      ax_r[2]  <= in_axis_z;
      bn_r[0]  <= in_field_n_x;
      bn_r[1]  <= in_field_n_y;
      bn_r[2]  <= in_field_n_z;
      for (int i = 0; i < 3; i++) s_r[i] <= mrp_q[i];
    end
    if (state_r == ST_WB) begin
      case (phase_r)
        PH_PRE: begin
          case (step_r)
            K_SQ1: sq_r[0] <= r28[29:0];
            K_SQ2: sq_r[1] <= r28[29:0];
            K_SQ3: sq_r[2] <= r28[29:0];
            K_P12: p12_r   <= r28[29:0];
            K_P13: p13_r   <= r28[29:0];
            K_P23: p23_r   <= r28[29:0];
            K_OM2: om2_r   <= r28[31:0];
            K_DEN: den_r   <= r28[DenW-1:0];
            K_A1:  a_r[0]  <= r28[30:0];
            K_A2:  a_r[1]  <= r28[30:0];
            K_A3:  a_r[2]  <= r28[30:0];
            default: ;
          endcase
        end
        PH_MAT: begin
          acc_r <= acc_sum;
          if (col_r == 2'd2) bb_r[row_r] <= bb_full[33:0];
        end
        PH_CRS: begin
          if (!step_r[0]) acc_r <= prod64;
          else tq_r[step_r[2:1]] <= t_sat;
        end
        default: ;
      endcase
    end
    if (state_r == ST_DWAIT && dv_sts.done) c_r[d_r] <= dv_quo;
  end

  assign out_valid    = out_valid_r;
  assign out_torque_x = tq_r[0];
  assign out_torque_y = tq_r[1];
  assign out_torque_z = tq_r[2];

  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT)
    else $error("result offered outside output state");

  a_bars_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bars_r <= MaxBars)
    else $error("bar count beyond limit");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> bars_r == '0 && dsum_r[0] == '0)
    else $error("dipole sum not cleared after result");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dv_sts.busy |-> state_r == ST_DWAIT)
    else $error("divider running outside wait state");

endmodule

[hdl/mtq_mul.sv]
module mtq_mul
  import mtq_pkg::*;
(
  input  logic  clk,
  input  mul_t  a,
  input  mul_t  b,
  output prod_t p
);

  prod_t p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

[hdl/mtq_div.sv]
module mtq_div
  import mtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_sts_t sts,
  output coef_t    quo
);

  logic            busy_r;
  logic            done_r;
  logic            neg_r;
  logic [CntW-1:0] cnt_r;
  logic [DvdW-1:0] dvd_r;
  logic [DenW-1:0] rem_r;
  logic [DenW-1:0] den_r;
  logic [CW-1:0]   q_r;
  logic [NumW-1:0] mag;
  logic [DenW:0]   rem_sh;
  logic            ge;
  logic [DenW-1:0] rem_nxt;
  logic [CW:0]     q_inc;
  logic [CW-1:0]   q_rnd;

  assign mag     = req.num[NumW-1] ? NumW'(-req.num) : NumW'(req.num);
  assign rem_sh  = {rem_r, dvd_r[DvdW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? DenW'(rem_sh - {1'b0, den_r}) : DenW'(rem_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {CntW{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      neg_r <= req.num[NumW-1];
      den_r <= req.den;
      dvd_r <= {mag[DenW-1:0], {(DvdW-DenW){1'b0}}};
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DvdW-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[CW-2:0], ge};
    end
  end

  assign q_inc = {1'b0, q_r} + 1'b1;
  assign q_rnd = q_inc[CW:1];
  assign quo   = neg_r ? coef_t'(-q_rnd) : coef_t'(q_rnd);
  assign sts   = '{busy: busy_r, done: done_r};

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mtq_pkg::*;

  typedef struct {
    logic               op;
    logic signed [23:0] cmd;
    logic [22:0]        lim;
    logic signed [17:0] ax, ay, az;
    logic signed [31:0] s1, s2, s3;
    logic signed [25:0] fx, fy, fz;
    bit                 hold;
  } beat_t;

  typedef struct {
    logic signed [47:0] tx, ty, tz;
  } torque_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_operation;
  logic signed [23:0] in_dipole_cmd;
  logic [22:0] in_dipole_limit;
  logic signed [17:0] in_axis_x, in_axis_y, in_axis_z;
  logic signed [31:0] in_mrp_one, in_mrp_two, in_mrp_three;
  logic signed [25:0] in_field_n_x, in_field_n_y, in_field_n_z;
  logic out_valid, out_stall;
  logic signed [47:0] out_torque_x, out_torque_y, out_torque_z;

  magnetorquer_torque_from_dipoles dut (.*);

  beat_t   beat_q[$];
  torque_t torque_q[$];
  beat_t   cur;
  longint  dip_sum[3];
  int      bars_held;
  int      errors;
  int      gap, stall_left, idle_cycles;
  bit      in_fire, out_fire, calm;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint rnd_half(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint q30_div(longint num, longint den);
    longint unsigned mag, d, q, r;
    mag = (num < 0) ? -num : num;
    d = den;
    q = mag / d;
    r = mag % d;
    for (int i = 0; i < 31; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    q = (q + 1) >> 1;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat_torque(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< 47) - 1;
    lo = -(longint'(1) <<< 47);
    return (v > hi) ? hi : (v < lo) ? lo : v;
  endfunction

  function automatic longint mrp_to_q28(logic signed [31:0] raw);
    longint s;
    s = raw;
    if (s > (longint'(1) <<< 30)) s = longint'(1) <<< 30;
    if (s < -(longint'(1) <<< 30)) s = -(longint'(1) <<< 30);
    return rnd_half(s, 2);
  endfunction

  function automatic torque_t body_torque(beat_t b);
    longint s[3], f[3], c[3][3], bb[3], m[3], t[3];
    longint sq1, sq2, sq3, ss, om, om2, den, p12, p13, p23, a1, a2, a3, acc;
    torque_t r;
    s[0] = mrp_to_q28(b.s1);
    s[1] = mrp_to_q28(b.s2);
    s[2] = mrp_to_q28(b.s3);
    f[0] = b.fx;
    f[1] = b.fy;
    f[2] = b.fz;
    sq1 = rnd_half(s[0] * s[0], 28);
    sq2 = rnd_half(s[1] * s[1], 28);
    sq3 = rnd_half(s[2] * s[2], 28);
    ss = sq1 + sq2 + sq3;
    om = (longint'(1) <<< 28) - ss;
    om2 = rnd_half(om * om, 28);
    den = rnd_half(((longint'(1) <<< 28) + ss) * ((longint'(1) <<< 28) + ss), 28);
    p12 = rnd_half(s[0] * s[1], 28);
    p13 = rnd_half(s[0] * s[2], 28);
    p23 = rnd_half(s[1] * s[2], 28);
    a1 = rnd_half(s[0] * om, 28);
    a2 = rnd_half(s[1] * om, 28);
    a3 = rnd_half(s[2] * om, 28);
    c[0][0] = q30_div(4 * (sq1 - sq2 - sq3) + om2, den);
    c[0][1] = q30_div(8 * p12 + 4 * a3, den);
    c[0][2] = q30_div(8 * p13 - 4 * a2, den);
    c[1][0] = q30_div(8 * p12 - 4 * a3, den);
    c[1][1] = q30_div(4 * (sq2 - sq1 - sq3) + om2, den);
    c[1][2] = q30_div(8 * p23 + 4 * a1, den);
    c[2][0] = q30_div(8 * p13 + 4 * a2, den);
    c[2][1] = q30_div(8 * p23 - 4 * a1, den);
    c[2][2] = q30_div(4 * (sq3 - sq1 - sq2) + om2, den);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += c[i][j] * f[j];
      bb[i] = rnd_half(acc, 30);
      m[i] = rnd_half(dip_sum[i], 16);
    end
    t[0] = m[1] * bb[2] - m[2] * bb[1];
    t[1] = m[2] * bb[0] - m[0] * bb[2];
    t[2] = m[0] * bb[1] - m[1] * bb[0];
    r.tx = 48'(sat_torque(rnd_half(t[0], 8)));
    r.ty = 48'(sat_torque(rnd_half(t[1], 8)));
    r.tz = 48'(sat_torque(rnd_half(t[2], 8)));
    return r;
  endfunction

  task automatic apply_beat(beat_t b);
    longint cmd, lim;
    if (b.op == OP_BAR) begin
      if (bars_held < 16) begin
        cmd = b.cmd;
        lim = longint'({1'b0, b.lim});
        if (cmd > lim) cmd = lim;
        else if (cmd < -lim) cmd = -lim;
        dip_sum[0] += cmd * longint'(b.ax);
        dip_sum[1] += cmd * longint'(b.ay);
        dip_sum[2] += cmd * longint'(b.az);
        bars_held++;
      end
    end else begin
      torque_q.push_back(body_torque(b));
      dip_sum = '{0, 0, 0};
      bars_held = 0;
    end
  endtask

  task automatic report(string what, logic signed [47:0] got, logic signed [47:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic logic signed [17:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'($urandom);
      default: return 18'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_mrp();
    case ($urandom_range(0, 7))
      0: return 32'sd1073741824;
      1: return -32'sd1073741824;
      2: return $urandom;
      default: return $urandom_range(0, 32'h7fffffff) - 32'sd1073741824;
    endcase
  endfunction

  function automatic beat_t rand_beat(logic op);
    beat_t b;
    b.op = op;
    b.cmd = 24'($urandom);
    b.lim = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 23'h7fffff));
    b.ax = pick_axis();
    b.ay = pick_axis();
    b.az = pick_axis();
    b.s1 = pick_mrp();
    b.s2 = pick_mrp();
    b.s3 = pick_mrp();
    b.fx = 26'($urandom);
    b.fy = 26'($urandom);
    b.fz = 26'($urandom);
    b.hold = 0;
    return b;
  endfunction

  initial begin
    beat_t b;
    int n, bars;
    rst_n = 0;
    in_valid = 0;
    in_operation = OP_BAR;
    in_dipole_cmd = 0;
    in_dipole_limit = 0;
    {in_axis_x, in_axis_y, in_axis_z} = '0;
    {in_mrp_one, in_mrp_two, in_mrp_three} = '0;
    {in_field_n_x, in_field_n_y, in_field_n_z} = '0;
    out_stall = 0;
    dip_sum = '{0, 0, 0};
    errors = 0;
    calm = 0;

    // finish with no bars
    b = rand_beat(OP_FINISH);
    beat_q.push_back(b);
    // command at the full limit, beyond a negative limit and beyond a zero limit, axis extremes
    b = rand_beat(OP_BAR);
    b.cmd = 24'sh7fffff; b.lim = 23'h7fffff;
    b.ax = 18'sd65536; b.ay = -18'sd65536; b.az = 18'sh1ffff;
    beat_q.push_back(b);
    b.cmd = -24'sh800000; b.lim = 23'h123456; b.az = -18'sh20000;
    beat_q.push_back(b);
    b.cmd = 24'sh7fffff; b.lim = 0;
    beat_q.push_back(b);
    b = rand_beat(OP_FINISH);
    b.s1 = 32'sh7fffffff; b.s2 = -32'sh80000000; b.s3 = 0;
    b.fx = 26'sh1ffffff; b.fy = -26'sh2000000; b.fz = 26'sh1ffffff;
    beat_q.push_back(b);
    // more bars than the sum takes, then a finish at the MRP clamp and field extremes
    for (int i = 0; i < 18; i++) begin
      b = rand_beat(OP_BAR);
      b.cmd = 24'sh7fffff; b.lim = 23'h7fffff;
      b.ax = 18'sd65536; b.ay = -18'sd65536; b.az = 18'sd65536;
      beat_q.push_back(b);
    end
    b = rand_beat(OP_FINISH);
    b.s1 = 32'sd1073741824; b.s2 = 32'sd1073741824; b.s3 = -32'sd1073741824;
    b.fx = -26'sh2000000; b.fy = 26'sh1ffffff; b.fz = -26'sh2000000;
    beat_q.push_back(b);
    // hold until the previous result has drained
    b = rand_beat(OP_FINISH);
    b.hold = 1;
    beat_q.push_back(b);

    n = 0;
    while (n < 1700) begin
      bars = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 8);
      for (int i = 0; i < bars; i++) beat_q.push_back(rand_beat(OP_BAR));
      b = rand_beat(OP_FINISH);
      b.hold = ($urandom_range(0, 40) == 0);
      beat_q.push_back(b);
      n += bars + 1;
    end

    repeat (10) @(negedge clk);
    rst_n <= 1;
    while (beat_q.size() > 0 || in_valid || torque_q.size() > 0) begin
      @(negedge clk);
      if ($urandom_range(0, 150) == 0) calm = ~calm;
    end
    repeat (700) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_beat(cur);
        in_fire = 1;
      end
      if (out_valid && !out_stall) begin
        out_fire = 1;
        if (torque_q.size() == 0) begin
          $display("unexpected result at %0t", $time);
          errors++;
        end else begin
          if (out_torque_x !== torque_q[0].tx) report("torque_x", out_torque_x, torque_q[0].tx);
          if (out_torque_y !== torque_q[0].ty) report("torque_y", out_torque_y, torque_q[0].ty);
          if (out_torque_z !== torque_q[0].tz) report("torque_z", out_torque_z, torque_q[0].tz);
          void'(torque_q.pop_front());
        end
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("FAILURE");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  always @(negedge clk) begin
    logic nv;
    if (rst_n) begin
      nv = in_valid;
      if (in_fire) begin
        nv = 0;
        in_fire = 0;
        gap = calm ? 0 : $urandom_range(0, 10);
      end
      if (!nv) begin
        if (gap > 0) gap--;
        else if (beat_q.size() > 0 && !(beat_q[0].hold && torque_q.size() > 0)) begin
          cur = beat_q.pop_front();
          in_operation <= cur.op;
          in_dipole_cmd <= cur.cmd;
          in_dipole_limit <= cur.lim;
          in_axis_x <= cur.ax;
          in_axis_y <= cur.ay;
          in_axis_z <= cur.az;
          in_mrp_one <= cur.s1;
          in_mrp_two <= cur.s2;
          in_mrp_three <= cur.s3;
          in_field_n_x <= cur.fx;
          in_field_n_y <= cur.fy;
          in_field_n_z <= cur.fz;
          nv = 1;
        end
      end
      in_valid <= nv;

      if (out_fire) begin
        out_fire = 0;
        stall_left = calm ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        if (out_valid) stall_left--;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end else begin
      gap = 0;
      stall_left = 0;
      in_fire = 0;
      out_fire = 0;
    end
  end

endmodule

[magnetorquer_torque_from_dipoles.f]
hdl/mtq_pkg.sv
hdl/mtq_mul.sv
hdl/mtq_div.sv
hdl/magnetorquer_torque_from_dipoles.sv
test/tb_top.sv
